[design/smo_pkg.sv]
// ----------------------------------------------------------------------------
// smo_pkg: shared types and codes of the stack machine
// opcode and status codes, and the command and status structs that join the
// controller to the datapath
// ----------------------------------------------------------------------------
`default_nettype none

package smo_pkg;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_PALL = 3'd1;
  localparam logic [OP_W-1:0] OP_PINT = 3'd2;
  localparam logic [OP_W-1:0] OP_POP  = 3'd3;
  localparam logic [OP_W-1:0] OP_SWAP = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE  = 3'd0;
  localparam logic [ST_W-1:0] ST_DATA  = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [ST_W-1:0] ST_SHORT = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd4;
  localparam logic [ST_W-1:0] ST_NONE  = 3'd5;

  // read address source
  typedef enum logic [1:0] {
    RD_TOP,
    RD_SECOND,
    RD_IDX_NEXT
  } rd_sel_t;

  // write address and data source
  typedef enum logic [1:0] {
    WR_PUSH,
    WR_TOP,
    WR_SECOND
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic            load_item;
    logic            rd_en;
    rd_sel_t         rd_sel;
    logic            wr_en;
    wr_sel_t         wr_sel;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            idx_load;
    logic            idx_dec;
    logic            tmp_load;
    logic            out_load;
    logic [ST_W-1:0] out_status;
    logic            out_use_rdata;
    logic            out_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            lt_two;
    logic            full;
    logic            idx_zero;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[design/stack_machine_ops.sv]
// ----------------------------------------------------------------------------
// stack_machine_ops: integer stack of a bytecode interpreter
// push, pop, swap, pint and pall on a stack of signed 32-bit values
// ----------------------------------------------------------------------------
// usage
//   in_*  : one request per handshake, opcode in in_tuser, push value in
//           in_tdata. a request is taken only while the block is idle.
//   out_* : results, status in out_tuser, reported element in out_tdata,
//           out_tlast on the final result of a request.
// sequencing (no stall)
//   push, pop, errors, unused opcodes: the execute state loads the result
//   into the output register and returns to idle.
//   pint: the execute state starts the registered read of the stack RAM,
//   and S_PINT then loads the read data as the result.
//   pall: the execute state reads the top, then one element per cycle while
//   the output register is free, top to bottom; idle after the bottom one.
//   swap: two reads and two writes through the one read and the one write
//   port of the stack RAM; the top is kept and the two entries exchanged.
// reset: rst_n low for one clock empties the stack and drops any result;
//   the RAM contents are not cleared, only entries below the count are read.
// stall: a result waits in the output register while out_tready is low; a
//   new request may be accepted meanwhile and halts before its first result.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_ops
  import smo_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] push_value
  input  wire logic [2:0]  in_tuser,   // [2:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [31:0] data_value
  output logic      [2:0]  out_tuser,  // [2:0] status
  output logic             out_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  smo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  smo_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_tuser),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_data   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

[design/smo_ram.sv]
// ----------------------------------------------------------------------------
// smo_ram: generic single-write, single-read RAM
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module smo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/smo_ctrl.sv]
// ----------------------------------------------------------------------------
// smo_ctrl: stack machine controller
// decodes one request at a time and sequences reads, writes and results
// ----------------------------------------------------------------------------
`default_nettype none

module smo_ctrl
  import smo_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PINT,
    S_PALL,
    S_SWAP1,
    S_SWAP2,
    S_SWAP3
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_PUSH: begin
            if (stat.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.wr_en      = 1'b1;
                cmd.wr_sel     = WR_PUSH;
                cmd.cnt_inc    = 1'b1;
                cmd.out_status = ST_DONE;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_POP: begin
            if (stat.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.cnt_dec    = 1'b1;
                cmd.out_status = ST_DONE;
              end
              state_nxt = S_IDLE;
            end
          end
          OP_PINT: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
              state_nxt  = S_PINT;
            end
          end
          OP_PALL: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_NONE;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_TOP;
              cmd.idx_load = 1'b1;
              state_nxt    = S_PALL;
            end
          end
          OP_SWAP: begin
            if (stat.lt_two) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_SHORT;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
              state_nxt  = S_SWAP1;
            end
          end
          default: begin
            // unused opcodes leave the stack alone
            if (stat.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = ST_DONE;
              state_nxt      = S_IDLE;
            end
          end
        endcase
      end
      S_PINT: begin
        if (stat.out_free) begin
          cmd.out_load      = 1'b1;
          cmd.out_last      = 1'b1;
          cmd.out_status    = ST_DATA;
          cmd.out_use_rdata = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      S_PALL: begin
        // one element per cycle while the result register is free, top to bottom
        if (stat.out_free) begin
          cmd.out_load      = 1'b1;
          cmd.out_last      = stat.idx_zero;
          cmd.out_status    = ST_DATA;
          cmd.out_use_rdata = 1'b1;
          if (stat.idx_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_IDX_NEXT;
            cmd.idx_dec = 1'b1;
          end
        end
      end
      S_SWAP1: begin
        // keep the top, fetch the one below
        cmd.tmp_load = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_SECOND;
        state_nxt    = S_SWAP2;
      end
      S_SWAP2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_TOP;
        state_nxt  = S_SWAP3;
      end
      S_SWAP3: begin
        if (stat.out_free) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WR_SECOND;
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = ST_DONE;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[design/smo_dpath.sv]
// ----------------------------------------------------------------------------
// smo_dpath: stack machine datapath
// element count, list index, stack RAM and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module smo_dpath
  import smo_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [VAL_W-1:0]  in_value,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic              out_tready,
  output logic                   out_valid,
  output logic      [ST_W-1:0]   out_status,
  output logic      [VAL_W-1:0]  out_data,
  output logic                   out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] tmp_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r;
  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r;
  logic [VAL_W-1:0] out_data_r;
  logic             out_last_r;

  logic [AW-1:0]    top_addr;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [VAL_W-1:0] rdata;

  assign top_addr = AW'(count_r - CW'(1));

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:      raddr = top_addr;
      RD_SECOND:   raddr = top_addr - AW'(1);
      RD_IDX_NEXT: raddr = idx_r - AW'(1);
      default:     raddr = top_addr;
    endcase
  end

  // write address and data select
  always_comb begin
    case (cmd.wr_sel)
      WR_PUSH: begin
        waddr = count_r[AW-1:0];
        wdata = value_r;
      end
      WR_TOP: begin
        waddr = top_addr;
        wdata = rdata;
      end
      WR_SECOND: begin
        waddr = top_addr - AW'(1);
        wdata = tmp_r;
      end
      default: begin
        waddr = count_r[AW-1:0];
        wdata = value_r;
      end
    endcase
  end

  smo_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // element count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r    <= in_op;
      value_r <= in_value;
    end
    if (cmd.tmp_load) begin
      tmp_r <= rdata;
    end
    if (cmd.idx_load) begin
      idx_r <= top_addr;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - AW'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_data_r   <= cmd.out_use_rdata ? rdata : '0;
      out_last_r   <= cmd.out_last;
    end
  end

  // status to the controller
  assign stat.op       = op_r;
  assign stat.empty    = (count_r == '0);
  assign stat.lt_two   = (count_r < CW'(2));
  assign stat.full     = (count_r >= DEPTH_C);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  // count stays within the stack
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("element count beyond depth");

  // no push into a full stack
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.full)
    else $error("push into full stack");

  // no pop from an empty stack
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !stat.empty)
    else $error("pop from empty stack");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

[test/tb_stack_machine_ops.sv]
// ----------------------------------------------------------------------------
// tb_stack_machine_ops: self-checking bench for the interpreter stack
// drives push, pop, swap, pint, pall and the unused opcodes through the
// request stream, keeps a shadow stack that computes the expected results,
// and compares every returned result field by field in arrival order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stack_machine_ops;
  import smo_pkg::*;

  localparam int STACK_DEPTH = 64;

  // opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
    logic             last;
  } stack_result_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata   = '0;
  logic [2:0]       in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [31:0]      out_tdata;
  logic [2:0]       out_tuser;
  logic             out_tlast;

  // shadow copy of the stack and the results it predicts
  logic [VAL_W-1:0] shadow_stack [STACK_DEPTH];
  int               shadow_depth = 0;
  stack_result_t    pending_results [$];

  int               err_count = 0;
  bit               in_gaps_on = 1'b0;
  bit               out_stalls_on = 1'b0;
  int               stall_left = 0;

  stack_machine_ops #(
    .DEPTH(STACK_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [31:0] push_value
    .in_tuser  (in_tuser),   // [2:0] op
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [31:0] data_value
    .out_tuser (out_tuser),  // [2:0] status
    .out_tlast (out_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------
  function automatic void queue_result(input logic [ST_W-1:0] status,
                                       input logic [VAL_W-1:0] value,
                                       input logic last);
    stack_result_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_stack_op(input logic [OP_W-1:0] op,
                                           input logic [VAL_W-1:0] value);
    logic [VAL_W-1:0] held;
    case (op)
      OP_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          shadow_stack[shadow_depth] = value;
          shadow_depth++;
          queue_result(ST_DONE, '0, 1'b1);
        end
      end
      OP_PALL: begin
        if (shadow_depth == 0) begin
          queue_result(ST_NONE, '0, 1'b1);
        end else begin
          // top to bottom, last only on the bottom element
          for (int k = shadow_depth - 1; k >= 0; k--)
            queue_result(ST_DATA, shadow_stack[k], k == 0);
        end
      end
      OP_PINT: begin
        if (shadow_depth == 0) queue_result(ST_EMPTY, '0, 1'b1);
        else queue_result(ST_DATA, shadow_stack[shadow_depth-1], 1'b1);
      end
      OP_POP: begin
        if (shadow_depth == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          shadow_depth--;
          queue_result(ST_DONE, '0, 1'b1);
        end
      end
      OP_SWAP: begin
        if (shadow_depth < 2) begin
          queue_result(ST_SHORT, '0, 1'b1);
        end else begin
          held = shadow_stack[shadow_depth-1];
          shadow_stack[shadow_depth-1] = shadow_stack[shadow_depth-2];
          shadow_stack[shadow_depth-2] = held;
          queue_result(ST_DONE, '0, 1'b1);
        end
      end
      default: queue_result(ST_DONE, '0, 1'b1);
    endcase
  endfunction

  // ------------------------------------------------------------------
  // result side: random stalls and checking
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic flag_result(input string why, input stack_result_t want,
                             input stack_result_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t mismatch (%s): want st=%0d val=%h last=%0b, got st=%0d val=%h last=%0b",
               $realtime, why, want.status, want.value, want.last,
               got.status, got.value, got.last);
  endtask

  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.value  = out_tdata;
      got.last   = out_tlast;
      if (pending_results.size() == 0) begin
        flag_result("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.value !== want.value ||
            got.last !== want.last)
          flag_result("field", want, got);
      end
    end
  end

  // ------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_stack_op(op, value);
  endtask

  // mostly random words, sometimes the signed extremes, zero and minus one
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_unused_op();
    case ($urandom_range(0, 2))
      0: return OP_RSVD5;
      1: return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

  // depth-aware mix so the stack wanders over its whole range
  function automatic logic [OP_W-1:0] pick_op();
    int r;
    int push_w;
    r = $urandom_range(0, 99);
    push_w = (shadow_depth < 40) ? 40 : 28;
    if (r < push_w) return OP_PUSH;
    if (r < push_w + 24) return OP_POP;
    if (r < push_w + 36) return OP_SWAP;
    if (r < push_w + 48) return OP_PINT;
    if (r < push_w + 55) return OP_PALL;
    return pick_unused_op();
  endfunction

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // empty stack errors, short swap, value extremes, unused opcodes
  task automatic test_empty_and_corners();
    send_request(OP_POP,   $urandom);
    send_request(OP_PINT,  $urandom);
    send_request(OP_SWAP,  $urandom);
    send_request(OP_PALL,  $urandom);
    send_request(OP_PUSH,  32'h7fff_ffff);
    send_request(OP_SWAP,  $urandom);
    send_request(OP_PINT,  $urandom);
    send_request(OP_PUSH,  32'h8000_0000);
    send_request(OP_PUSH,  32'h0000_0000);
    send_request(OP_PUSH,  32'hffff_ffff);
    send_request(OP_PALL,  $urandom);
    send_request(OP_SWAP,  $urandom);
    send_request(OP_PINT,  $urandom);
    send_request(OP_PALL,  $urandom);
    send_request(OP_RSVD5, $urandom);
    send_request(OP_RSVD6, $urandom);
    send_request(OP_RSVD7, $urandom);
    send_request(OP_POP,   $urandom);
    send_request(OP_POP,   $urandom);
    send_request(OP_POP,   $urandom);
    send_request(OP_PINT,  $urandom);
    send_request(OP_POP,   $urandom);
    send_request(OP_POP,   $urandom);
    send_request(OP_PALL,  $urandom);
  endtask

  // push until full, then push into a full stack, list all of it, and swap, read, pop and push at the top
  task automatic test_fill_to_full();
    while (shadow_depth < STACK_DEPTH) send_request(OP_PUSH, pick_value());
    repeat (3) send_request(OP_PUSH, pick_value());
    send_request(OP_PALL, $urandom);
    send_request(OP_SWAP, $urandom);
    send_request(OP_PINT, $urandom);
    send_request(OP_POP,  $urandom);
    send_request(OP_PUSH, pick_value());
    send_request(OP_PUSH, pick_value());
  endtask

  // pop down to empty with reads and swaps on the way, then the empty cases
  task automatic test_drain_to_empty();
    while (shadow_depth > 0) begin
      case ($urandom_range(0, 5))
        0: send_request(OP_PINT, $urandom);
        1: send_request(OP_SWAP, $urandom);
        default: send_request(OP_POP, $urandom);
      endcase
    end
    send_request(OP_POP,  $urandom);
    send_request(OP_PINT, $urandom);
    send_request(OP_PALL, $urandom);
    send_request(OP_PUSH, pick_value());
    send_request(OP_SWAP, $urandom);
    send_request(OP_PALL, $urandom);
  endtask

  task automatic test_random_mix(input int count);
    logic [OP_W-1:0] op;
    repeat (count) begin
      op = pick_op();
      send_request(op, (op == OP_PUSH) ? pick_value() : $urandom);
    end
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    test_empty_and_corners();
    test_fill_to_full();

    in_gaps_on = 1'b0;
    test_drain_to_empty();

    in_gaps_on = 1'b1;
    test_random_mix(130);

    // back to back with the result side always ready
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    test_random_mix(80);
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[stack_machine_ops.f]
design/smo_pkg.sv
design/smo_ram.sv
design/smo_ctrl.sv
design/smo_dpath.sv
design/stack_machine_ops.sv
test/tb_stack_machine_ops.sv
